// ===== rtl/msts_pkg.sv =====
// shared types, codes and helper functions for the trigger sequencer
package msts_pkg;

    localparam int unsigned TRACKS_DEFAULT = 8;
    localparam int unsigned STEPS_DEFAULT  = 16;
    localparam int unsigned COUNT_W        = 5;
    localparam int unsigned COUNT_CODES    = 1 << COUNT_W;
    localparam int unsigned NUM_W          = 7;
    localparam int unsigned MASK_W         = 8;

    typedef enum logic [2:0] {
        OP_PROGRAM = 3'd0,
        OP_TICK    = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESTART = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         track;
        logic [COUNT_W-1:0] hit_count;
        logic [3:0]         offset;
    } req_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] trigger_mask;
        logic [3:0]        step_now;
        logic              is_running;
    } rsp_item_t;

    // remainder of a narrow value by repeated subtraction
    function automatic logic [NUM_W-1:0] mod_sub(input logic [NUM_W-1:0] value,
                                                 input logic [NUM_W-1:0] modulus);
        logic [NUM_W-1:0] r;
        r = value;
        for (int i = 0; i < 8; i++) begin
            if (r >= modulus) begin
                r = r - modulus;
            end
        end
        return r;
    endfunction

    // unrotated hit pattern for one raw hit count, evaluated at elaboration
    function automatic logic [63:0] base_pattern(input int unsigned n,
                                                 input int unsigned steps);
        int unsigned c;
        int unsigned space;
        int unsigned rem;
        int unsigned pos;
        logic [63:0] bits;
        c     = n;
        space = 0;
        rem   = steps;
        bits  = '0;
        for (int i = 0; i < 32; i++) begin
            if (c >= steps + 1) begin
                c = c - (steps + 1);
            end
        end
        if (c != 0) begin
            for (int i = 0; i < 65; i++) begin
                if (rem >= c) begin
                    rem   = rem - c;
                    space = space + 1;
                end
            end
            for (int j = 0; j < 64; j++) begin
                pos = j * space;
                if (pos < steps) begin
                    bits[pos[5:0]] = 1'b1;
                end
            end
        end
        return bits;
    endfunction

endpackage

// ===== rtl/msts_pattern_gen.sv =====
// builds one track pattern from a hit count and an offset
module msts_pattern_gen
    import msts_pkg::*;
#(
    parameter int unsigned STEPS = STEPS_DEFAULT,
    localparam int unsigned PW = (STEPS > 1) ? $clog2(STEPS) : 1
) (
    input  logic [COUNT_W-1:0] hit_count,
    input  logic [PW-1:0]      rotate,
    output logic [STEPS-1:0]   pattern
);

    logic [STEPS-1:0]   base_tbl [COUNT_CODES];
    logic [STEPS-1:0]   base;
    logic [2*STEPS-1:0] dbl;

    for (genvar g = 0; g < COUNT_CODES; g++) begin : g_tbl
        localparam logic [63:0] BASE = base_pattern(g, STEPS);
        assign base_tbl[g] = BASE[STEPS-1:0];
    end

    always_comb
    begin
        base    = base_tbl[hit_count];
        dbl     = {base, base} << rotate;
        pattern = dbl[2*STEPS-1:STEPS];
    end

endmodule

// ===== rtl/msts_pattern_store.sv =====
// per-track pattern registers with one write port and a step column read
module msts_pattern_store
    import msts_pkg::*;
#(
    parameter int unsigned TRACKS = TRACKS_DEFAULT,
    parameter int unsigned STEPS  = STEPS_DEFAULT,
    localparam int unsigned TW = (TRACKS > 1) ? $clog2(TRACKS) : 1,
    localparam int unsigned PW = (STEPS > 1) ? $clog2(STEPS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [TW-1:0]     wr_track,
    input  logic [STEPS-1:0]  wr_pattern,
    input  logic [PW-1:0]     rd_step,
    output logic [TRACKS-1:0] hit_mask
);

    logic [STEPS-1:0] pattern_reg [TRACKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                pattern_reg[t] <= '0;
            end
        end else if (wr_en) begin
            pattern_reg[wr_track] <= wr_pattern;
        end
    end

    always_comb
    begin
        for (int t = 0; t < TRACKS; t++) begin
            hit_mask[t] = pattern_reg[t][rd_step];
        end
    end

endmodule

// ===== rtl/multi_track_spaced_trigger_sequencer.sv =====
// top level: input register, event decode, shared step state and result register
//
// Multi-track trigger sequencer with evenly spaced hits. Every event (program,
// tick, start, stop, restart) is taken into an input register and produces
// exactly one result item, passed on through a result register, so the
// block accepts one event per clock while results flow freely; a held result
// stalls the input only once both registers are full. Program events rewrite a
// track pattern from a constant hit-spacing table and a rotate; ticks advance
// the shared step while running and report the tracks that hit on the new step
// (tracks beyond the eighth are not reported). Reset clears all patterns, the
// step and the run flag.
module multi_track_spaced_trigger_sequencer
    import msts_pkg::*;
#(
    parameter int unsigned TRACKS = TRACKS_DEFAULT,
    parameter int unsigned STEPS  = STEPS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int unsigned TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int unsigned PW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned MW = (TRACKS < MASK_W) ? TRACKS : MASK_W;

    req_item_t         item_reg;
    logic              item_valid_reg;
    rsp_item_t         rsp_reg;
    logic              rsp_valid_reg;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic              running_reg;
    logic              running_next;
    logic              advance;
    logic              wr_en;
    logic [TW-1:0]     wr_track;
    logic [PW-1:0]     rotate;
    logic [STEPS-1:0]  new_pattern;
    logic [TRACKS-1:0] hit_mask;
    logic [MASK_W-1:0] mask_next;
    rsp_item_t         rsp_next;

    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !item_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wr_track = TW'(mod_sub(NUM_W'(item_reg.track), NUM_W'(TRACKS)));
    assign rotate   = PW'(mod_sub(NUM_W'(item_reg.offset), NUM_W'(STEPS)));

    msts_pattern_gen #(
        .STEPS(STEPS)
    ) u_gen (
        .hit_count(item_reg.hit_count),
        .rotate   (rotate),
        .pattern  (new_pattern)
    );

    msts_pattern_store #(
        .TRACKS(TRACKS),
        .STEPS (STEPS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_track  (wr_track),
        .wr_pattern(new_pattern),
        .rd_step   (pos_next),
        .hit_mask  (hit_mask)
    );

    always_comb
    begin
        pos_next     = pos_reg;
        running_next = running_reg;
        wr_en        = 1'b0;
        mask_next    = '0;
        unique case (op_t'(item_reg.operation))
            OP_PROGRAM: begin
                wr_en = advance;
            end
            OP_TICK: begin
                if (running_reg) begin
                    pos_next  = (pos_reg == PW'(STEPS - 1)) ? '0 : pos_reg + 1'b1;
                    mask_next = MASK_W'(hit_mask[MW-1:0]);
                end
            end
            OP_START: begin
                running_next = 1'b1;
            end
            OP_STOP: begin
                running_next = 1'b0;
            end
            OP_RESTART: begin
                running_next = 1'b1;
                pos_next     = '0;
            end
            default: begin
                pos_next = pos_reg;
            end
        endcase
        rsp_next.trigger_mask = mask_next;
        rsp_next.step_now     = 4'(pos_next);
        rsp_next.is_running   = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            running_reg    <= 1'b0;
        end else begin
            if (req_ready) begin
                item_valid_reg <= req_valid;
            end
            if (advance) begin
                rsp_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                running_reg   <= running_next;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready) begin
            item_reg <= req;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== sim/multi_track_spaced_trigger_sequencer_tb.sv =====
// testbench for the trigger sequencer: directed table, random events and a step predictor
module multi_track_spaced_trigger_sequencer_tb;
    import msts_pkg::*;

    localparam int unsigned TRACK_COUNT  = 8;
    localparam int unsigned STEP_COUNT   = 16;
    localparam int          RANDOM_ITEMS = 1550;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PRINT_LIMIT  = 40;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PATTERN
    } ready_mode_t;

    typedef struct {
        req_item_t stim;
        bit        typed;
        rsp_item_t want;
    } plan_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    req_item_t req       = '0;
    logic      rsp_ready = 1'b0;
    logic      req_ready;
    logic      rsp_valid;
    rsp_item_t rsp;

    logic [STEP_COUNT-1:0] track_pattern [TRACK_COUNT];
    logic [3:0]            play_step;
    logic                  play_on;

    rsp_item_t   pending_results [$];
    plan_row_t   plan [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;
    int          mode_left   = 0;

    multi_track_spaced_trigger_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("[%0d] mismatch: %s", cycle_count, what);
        end
    endtask

    function automatic void clear_sequencer();
        for (int t = 0; t < TRACK_COUNT; t++)
        begin
            track_pattern[t] = '0;
        end
        play_step = '0;
        play_on   = 1'b0;
    endfunction

    function automatic rsp_item_t advance_sequencer(input req_item_t item);
        rsp_item_t             res;
        logic [4:0]            hits;
        int unsigned           spacing;
        logic [STEP_COUNT-1:0] bits;
        res  = '0;
        bits = '0;
        case (item.operation)
            OP_PROGRAM:
            begin
                hits = item.hit_count;
                if (hits > STEP_COUNT)
                begin
                    hits = 5'(hits - (STEP_COUNT + 1));
                end
                if (hits != 0)
                begin
                    spacing = STEP_COUNT / hits;
                    for (int unsigned k = 0; k < STEP_COUNT; k += spacing)
                    begin
                        bits[4'((item.offset + k) % STEP_COUNT)] = 1'b1;
                    end
                end
                track_pattern[item.track] = bits;
            end
            OP_TICK:
            begin
                if (play_on)
                begin
                    play_step = play_step + 4'd1;
                    for (int t = 0; t < TRACK_COUNT; t++)
                    begin
                        res.trigger_mask[t] = track_pattern[t][play_step];
                    end
                end
            end
            OP_START:
            begin
                play_on = 1'b1;
            end
            OP_STOP:
            begin
                play_on = 1'b0;
            end
            OP_RESTART:
            begin
                play_on   = 1'b1;
                play_step = '0;
            end
            default:
            begin
            end
        endcase
        res.step_now   = play_step;
        res.is_running = play_on;
        return res;
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [2:0] trk,
                                    input logic [4:0] cnt, input logic [3:0] ofs,
                                    input bit typed, input logic [7:0] mask,
                                    input logic [3:0] step, input logic run);
        plan_row_t row;
        row.stim       = '{operation: op, track: trk, hit_count: cnt, offset: ofs};
        row.typed      = typed;
        row.want       = '{trigger_mask: mask, step_now: step, is_running: run};
        plan.push_back(row);
    endfunction

    function automatic req_item_t random_event();
        req_item_t   item;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        item.track     = 3'($urandom_range(0, TRACK_COUNT - 1));
        item.offset    = 4'($urandom_range(0, STEP_COUNT - 1));
        item.hit_count = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(0, STEP_COUNT)
                                                        : $urandom_range(STEP_COUNT + 1, 31));
        if (pick < 25)
        begin
            item.operation = OP_PROGRAM;
        end
        else if (pick < 75)
        begin
            item.operation = OP_TICK;
        end
        else if (pick < 81)
        begin
            item.operation = OP_START;
        end
        else if (pick < 85)
        begin
            item.operation = OP_STOP;
        end
        else if (pick < 91)
        begin
            item.operation = OP_RESTART;
        end
        else
        begin
            item.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return item;
    endfunction

    task automatic offer(input req_item_t item, input bit typed, input rsp_item_t want);
        rsp_item_t guess;
        req       <= item;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        guess = advance_sequencer(item);
        pending_results.push_back(typed ? want : guess);
    endtask

    // receiver stalls in four modes (always, mostly, rarely, patterned ready) that change at random
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 80);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:  rsp_ready <= 1'b1;
            READY_MOSTLY:  rsp_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:  rsp_ready <= ($urandom_range(0, 3) == 0);
            default:       rsp_ready <= (mode_left % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result with no item pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.trigger_mask !== want.trigger_mask)
                begin
                    flag_mismatch($sformatf("trigger_mask %h, predicted %h",
                                            rsp.trigger_mask, want.trigger_mask));
                end
                if (rsp.step_now !== want.step_now)
                begin
                    flag_mismatch($sformatf("step_now %0d, predicted %0d",
                                            rsp.step_now, want.step_now));
                end
                if (rsp.is_running !== want.is_running)
                begin
                    flag_mismatch($sformatf("is_running %b, predicted %b",
                                            rsp.is_running, want.is_running));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("multi_track_spaced_trigger_sequencer verification failed");
            $finish;
        end
    end

    initial
    begin
        int        burst_left;
        int        gap;
        int        total;
        int        pause_at;
        req_item_t item;
        bit        typed;
        rsp_item_t want;

        clear_sequencer();
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_SPARE_HI, 3'd7, 5'd31, 4'd15, 1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd0, 5'd16, 4'd0,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd7, 5'd1,  4'd15, 1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd3, 5'd31, 4'd15, 1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd1, 5'd17, 4'd5,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd2, 5'd4,  4'd3,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd5, 5'd3,  4'd0,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd6, 5'd0,  4'd9,  1, 8'h00, 4'd0, 1'b0);
        add_row(OP_START,    3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd0, 1'b1);
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);
        add_row(OP_TICK,     3'd7, 5'd31, 4'd15, 0, 8'h00, 4'd0, 1'b0);
        add_row(OP_SPARE_LO, 3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);
        add_row(OP_STOP,     3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd2, 1'b0);
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);
        add_row(OP_START,    3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd2, 1'b1);
        add_row(OP_RESTART,  3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd0, 1'b1);
        add_row(OP_PROGRAM,  3'd4, 5'd16, 4'd15, 1, 8'h00, 4'd0, 1'b1);
        add_row(OP_SPARE_MID, 3'd2, 5'd9, 4'd6,  1, 8'h00, 4'd0, 1'b1);
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);
        add_row(OP_PROGRAM,  3'd0, 5'd0,  4'd0,  1, 8'h00, 4'd2, 1'b1);
        add_row(OP_TICK,     3'd0, 5'd0,  4'd0,  0, 8'h00, 4'd0, 1'b0);

        total      = plan.size() + RANDOM_ITEMS;
        pause_at   = plan.size() + RANDOM_ITEMS / 2;
        burst_left = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
            begin
                req_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending_results.size() != 0);
            end
            else if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                          : $urandom_range(1, 24);
            end
            if (burst_left > 0)
            begin
                burst_left--;
            end
            if (i < plan.size())
            begin
                item  = plan[i].stim;
                typed = plan[i].typed;
                want  = plan[i].want;
            end
            else
            begin
                item  = random_event();
                typed = 1'b0;
                want  = '0;
            end
            offer(item, typed, want);
        end

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("multi_track_spaced_trigger_sequencer verification clean");
        end
        else
        begin
            $display("multi_track_spaced_trigger_sequencer verification failed");
        end
        $finish;
    end

endmodule
